// ===== hdl/i2c_register_master_macros.svh =====
// Assertion macros used by the checker file.
`ifndef I2C_REGISTER_MASTER_MACROS_SVH
`define I2C_REGISTER_MASTER_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define RM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define RM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/i2c_rm_pkg.sv =====
package i2c_rm_pkg;

   localparam int BURST_DEPTH = 16;
   localparam int BUF_AW      = $clog2(BURST_DEPTH);

   localparam logic [7:0] READ_BIT = 8'h01;
   localparam logic [7:0] MSB_MASK = 8'h80;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_START = 2'd1,
      MODE_LOAD  = 2'd2
   } mode_type;

   typedef enum logic [4:0] {
      PH_IDLE, PH_START, PH_TX_LOW, PH_TX_HIGH, PH_ACK_LOW, PH_ACK_HIGH,
      PH_RS_LOW, PH_RS_HIGH, PH_RS_FALL, PH_RX_LOW, PH_RX_HIGH,
      PH_MA_LOW, PH_MA_HIGH, PH_SP_LOW, PH_SP_HIGH, PH_SP_RISE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_ADDR_W, KIND_REG, KIND_ADDR_R, KIND_DATA
   } kind_type;

endpackage

// ===== hdl/i2c_register_master.sv =====
// Channel   Direction  Words carried
// req_      in         tick, start transaction or buffer load, with sampled SDA
// rsp_      out        line levels after the word, busy, received byte, ack report
//
// Each accepted request yields one response word; one per cycle while rsp_ready is high.
// The bus sequencer and write buffer update in the cycle of acceptance, and the
// response sits in an output register the next cycle.
// A new request is taken while the response register is empty or being emptied.
// Reset clears the sequencer to idle with both lines released; the buffer is not cleared.
module i2c_register_master
   import i2c_rm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic       req_is_read,
   input  logic [6:0] req_device_address,
   input  logic [7:0] req_register_address,
   input  logic [4:0] req_byte_count,
   input  logic [3:0] req_buffer_index,
   input  logic [7:0] req_data_byte,
   input  logic       req_sda_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_scl,
   output logic       rsp_sda_out,
   output logic       rsp_busy_res,
   output logic [7:0] rsp_read_data,
   output logic       rsp_read_valid,
   output logic       rsp_read_last,
   output logic       rsp_ack_valid,
   output logic       rsp_nack
);

   phase_type  phase_ff, phase_in;
   kind_type   kind_ff, kind_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] shift_ff, shift_in;
   logic [4:0] byte_index_ff, byte_index_in;
   logic [4:0] burst_length_ff, burst_length_in;
   logic       read_burst_ff, read_burst_in;
   logic [6:0] target_ff, target_in;
   logic [7:0] start_reg_ff, start_reg_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in_lvl;
   logic [7:0] write_buffer_ff [BURST_DEPTH];

   logic        rsp_valid_ff;
   logic        rsp_scl_ff, rsp_sda_ff, rsp_busy_ff;
   logic [7:0]  rsp_data_ff, rd_data_in;
   logic        rsp_rvalid_ff, rd_valid_in;
   logic        rsp_rlast_ff, rd_last_in;
   logic        rsp_avalid_ff, ack_valid_in;
   logic        rsp_nack_ff, nack_in;

   logic              accept;
   logic [BUF_AW-1:0] buf_addr;
   logic [7:0]        buf_word;
   logic [4:0]        next_index;
   logic              last_byte;
   logic [4:0]        count_sat;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign next_index = byte_index_ff + 5'd1;
   assign last_byte  = (next_index >= burst_length_ff);
   assign buf_addr   = (kind_ff == KIND_DATA) ? next_index[BUF_AW-1:0] : '0;
   assign buf_word   = write_buffer_ff[buf_addr];

   always_comb begin
      if (req_byte_count == 5'd0) begin
         count_sat = 5'd1;
      end else if (req_byte_count > 5'(BURST_DEPTH)) begin
         count_sat = 5'(BURST_DEPTH);
      end else begin
         count_sat = req_byte_count;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      kind_in         = kind_ff;
      bit_count_in    = bit_count_ff;
      shift_in        = shift_ff;
      byte_index_in   = byte_index_ff;
      burst_length_in = burst_length_ff;
      read_burst_in   = read_burst_ff;
      target_in       = target_ff;
      start_reg_in    = start_reg_ff;
      scl_in          = scl_ff;
      sda_in_lvl      = sda_ff;
      rd_data_in      = 8'd0;
      rd_valid_in     = 1'b0;
      rd_last_in      = 1'b0;
      ack_valid_in    = 1'b0;
      nack_in         = 1'b0;

      case (mode_type'(req_mode))
         MODE_START: begin
            if (phase_ff == PH_IDLE) begin
               burst_length_in = count_sat;
               read_burst_in   = req_is_read;
               target_in       = req_device_address;
               start_reg_in    = req_register_address;
               byte_index_in   = 5'd0;
               bit_count_in    = 4'd0;
               shift_in        = 8'd0;
               kind_in         = KIND_ADDR_W;
               phase_in        = PH_START;
            end
         end
         MODE_TICK: begin
            case (phase_ff)
               PH_IDLE: begin
                  scl_in     = 1'b1;
                  sda_in_lvl = 1'b1;
               end
               PH_START: begin
                  scl_in       = 1'b1;
                  sda_in_lvl   = 1'b0;
                  shift_in     = {target_ff, 1'b0};
                  bit_count_in = 4'd0;
                  kind_in      = KIND_ADDR_W;
                  phase_in     = PH_TX_LOW;
               end
               PH_TX_LOW: begin
                  scl_in     = 1'b0;
                  sda_in_lvl = |(shift_ff & MSB_MASK);
                  phase_in   = PH_TX_HIGH;
               end
               PH_TX_HIGH: begin
                  scl_in       = 1'b1;
                  shift_in     = {shift_ff[6:0], 1'b0};
                  bit_count_in = bit_count_ff + 4'd1;
                  phase_in     = (bit_count_in >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
               end
               PH_ACK_LOW: begin
                  scl_in     = 1'b0;
                  sda_in_lvl = 1'b1;
                  phase_in   = PH_ACK_HIGH;
               end
               PH_ACK_HIGH: begin
                  scl_in       = 1'b1;
                  ack_valid_in = 1'b1;
                  nack_in      = req_sda_in;
                  case (kind_ff)
                     KIND_ADDR_W: begin
                        shift_in     = start_reg_ff;
                        bit_count_in = 4'd0;
                        kind_in      = KIND_REG;
                        phase_in     = PH_TX_LOW;
                     end
                     KIND_REG: begin
                        if (read_burst_ff) begin
                           phase_in = PH_RS_LOW;
                        end else begin
                           byte_index_in = 5'd0;
                           shift_in      = buf_word;
                           bit_count_in  = 4'd0;
                           kind_in       = KIND_DATA;
                           phase_in      = PH_TX_LOW;
                        end
                     end
                     KIND_ADDR_R: begin
                        byte_index_in = 5'd0;
                        bit_count_in  = 4'd0;
                        shift_in      = 8'd0;
                        phase_in      = PH_RX_LOW;
                     end
                     default: begin
                        byte_index_in = next_index;
                        if (last_byte) begin
                           phase_in = PH_SP_LOW;
                        end else begin
                           shift_in     = buf_word;
                           bit_count_in = 4'd0;
                           kind_in      = KIND_DATA;
                           phase_in     = PH_TX_LOW;
                        end
                     end
                  endcase
               end
               PH_RS_LOW: begin
                  scl_in     = 1'b0;
                  sda_in_lvl = 1'b1;
                  phase_in   = PH_RS_HIGH;
               end
               PH_RS_HIGH: begin
                  scl_in     = 1'b1;
                  sda_in_lvl = 1'b1;
                  phase_in   = PH_RS_FALL;
               end
               PH_RS_FALL: begin
                  scl_in       = 1'b1;
                  sda_in_lvl   = 1'b0;
                  shift_in     = {target_ff, 1'b0} | READ_BIT;
                  bit_count_in = 4'd0;
                  kind_in      = KIND_ADDR_R;
                  phase_in     = PH_TX_LOW;
               end
               PH_RX_LOW: begin
                  scl_in     = 1'b0;
                  sda_in_lvl = 1'b1;
                  phase_in   = PH_RX_HIGH;
               end
               PH_RX_HIGH: begin
                  scl_in       = 1'b1;
                  shift_in     = {shift_ff[6:0], req_sda_in};
                  bit_count_in = bit_count_ff + 4'd1;
                  if (bit_count_in >= 4'd8) begin
                     rd_valid_in = 1'b1;
                     rd_data_in  = shift_in;
                     rd_last_in  = last_byte;
                     phase_in    = PH_MA_LOW;
                  end else begin
                     phase_in = PH_RX_LOW;
                  end
               end
               PH_MA_LOW: begin
                  scl_in     = 1'b0;
                  sda_in_lvl = last_byte;
                  phase_in   = PH_MA_HIGH;
               end
               PH_MA_HIGH: begin
                  scl_in        = 1'b1;
                  byte_index_in = next_index;
                  bit_count_in  = 4'd0;
                  shift_in      = 8'd0;
                  phase_in      = last_byte ? PH_SP_LOW : PH_RX_LOW;
               end
               PH_SP_LOW: begin
                  scl_in     = 1'b0;
                  sda_in_lvl = 1'b0;
                  phase_in   = PH_SP_HIGH;
               end
               PH_SP_HIGH: begin
                  scl_in     = 1'b1;
                  sda_in_lvl = 1'b0;
                  phase_in   = PH_SP_RISE;
               end
               PH_SP_RISE: begin
                  scl_in     = 1'b1;
                  sda_in_lvl = 1'b1;
                  phase_in   = PH_IDLE;
               end
               default: begin
                  scl_in     = 1'b1;
                  sda_in_lvl = 1'b1;
                  phase_in   = PH_IDLE;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         kind_ff         <= KIND_ADDR_W;
         bit_count_ff    <= 4'd0;
         shift_ff        <= 8'd0;
         byte_index_ff   <= 5'd0;
         burst_length_ff <= 5'd0;
         read_burst_ff   <= 1'b0;
         target_ff       <= 7'd0;
         start_reg_ff    <= 8'd0;
         scl_ff          <= 1'b1;
         sda_ff          <= 1'b1;
      end else if (accept) begin
         phase_ff        <= phase_in;
         kind_ff         <= kind_in;
         bit_count_ff    <= bit_count_in;
         shift_ff        <= shift_in;
         byte_index_ff   <= byte_index_in;
         burst_length_ff <= burst_length_in;
         read_burst_ff   <= read_burst_in;
         target_ff       <= target_in;
         start_reg_ff    <= start_reg_in;
         scl_ff          <= scl_in;
         sda_ff          <= sda_in_lvl;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (mode_type'(req_mode) == MODE_LOAD)) begin
         write_buffer_ff[req_buffer_index] <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_scl_ff    <= scl_in;
         rsp_sda_ff    <= sda_in_lvl;
         rsp_busy_ff   <= (phase_in != PH_IDLE);
         rsp_data_ff   <= rd_data_in;
         rsp_rvalid_ff <= rd_valid_in;
         rsp_rlast_ff  <= rd_last_in;
         rsp_avalid_ff <= ack_valid_in;
         rsp_nack_ff   <= nack_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl        = rsp_scl_ff;
   assign rsp_sda_out    = rsp_sda_ff;
   assign rsp_busy_res   = rsp_busy_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_read_valid = rsp_rvalid_ff;
   assign rsp_read_last  = rsp_rlast_ff;
   assign rsp_ack_valid  = rsp_avalid_ff;
   assign rsp_nack       = rsp_nack_ff;

endmodule

// ===== hdl/i2c_rm_checker.sv =====
`include "i2c_register_master_macros.svh"

module i2c_rm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_scl,
   input logic       rsp_sda_out,
   input logic       rsp_busy_res,
   input logic [7:0] rsp_read_data,
   input logic       rsp_read_valid,
   input logic       rsp_read_last,
   input logic       rsp_ack_valid,
   input logic       rsp_nack
);

   logic [15:0] rsp_view;
   logic        two_reports;
   logic        flags_ok;
   logic        idle_word;

   assign rsp_view    = {rsp_valid, rsp_read_data, rsp_scl, rsp_sda_out, rsp_busy_res,
                         rsp_read_valid, rsp_read_last, rsp_ack_valid, rsp_nack};
   assign two_reports = rsp_read_valid && rsp_ack_valid;
   assign flags_ok    = (!rsp_read_last || rsp_read_valid) && (!rsp_nack || rsp_ack_valid);
   assign idle_word   = rsp_valid && !rsp_busy_res;

   `RM_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid, "response word present after reset")
   `RM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> $stable(rsp_view), "stalled word changed")
   `RM_ASSERT(a_one_report, rsp_valid |-> !two_reports, "byte and ack reported in one word")
   `RM_ASSERT(a_flag_qual, rsp_valid |-> flags_ok, "qualifier missing for last or nack flag")
   `RM_ASSERT(a_idle_release, idle_word |-> rsp_scl && rsp_sda_out, "bus lines held while idle")

endmodule

bind i2c_register_master i2c_rm_checker u_i2c_rm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_scl        (rsp_scl),
   .rsp_sda_out    (rsp_sda_out),
   .rsp_busy_res   (rsp_busy_res),
   .rsp_read_data  (rsp_read_data),
   .rsp_read_valid (rsp_read_valid),
   .rsp_read_last  (rsp_read_last),
   .rsp_ack_valid  (rsp_ack_valid),
   .rsp_nack       (rsp_nack)
);
